// ===== rtl/core/ntvm_pkg.sv =====
// shared constants, types and helper functions for the name-then-verb matcher
package ntvm_pkg;

	localparam int NAME_MAX_BYTES = 16;
	localparam int WINDOW_BYTES   = 26;
	localparam int PAT_COUNT      = 9;
	localparam int PAT_MAX        = 9;

	localparam int NAME_REG_BYTES = 16;
	localparam int LEN_W          = $clog2(NAME_MAX_BYTES + 1);
	localparam int WIN_IDX_W      = $clog2(WINDOW_BYTES);
	localparam int SEEN_W         = 5;
	localparam int REG_IDX_W      = 2;

	localparam logic [7:0] CASE_OFFSET = 8'd32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_NAME_LOW  = 2'd0,
		REG_NAME_HIGH = 2'd1,
		REG_NAME_LEN  = 2'd2
	} reg_idx_t;

	localparam logic [7:0] PAT_TEXT [PAT_COUNT][PAT_MAX] = '{
		'{" ", "i", "s", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{" ", "w", "a", "s", " ", 8'h00, 8'h00, 8'h00, 8'h00},
		'{" ", "w", "o", "u", "l", "d", " ", 8'h00, 8'h00},
		'{" ", "s", "h", "o", "u", "l", "d", " ", 8'h00},
		'{" ", "t", "h", "i", "n", "k", "s", " ", 8'h00},
		'{" ", "f", "e", "e", "l", "s", " ", 8'h00, 8'h00},
		'{" ", "i", "s", " ", "c", "h", "i", "l", "l"},
		'{" ", "i", "s", " ", "a", " ", 8'h00, 8'h00, 8'h00},
		'{" ", "i", "s", " ", "t", "h", "e", " ", 8'h00}
	};

	localparam logic [3:0] PAT_LEN [PAT_COUNT] = '{
		4'd4, 4'd5, 4'd7, 4'd8, 4'd8, 4'd7, 4'd9, 4'd6, 4'd8
	};

	typedef struct packed {
		logic [WINDOW_BYTES-1:0][7:0] bytes;
		logic [SEEN_W-1:0]            seen;
	} win_t;

	typedef struct packed {
		logic [NAME_MAX_BYTES-1:0][7:0] rname;
		logic [LEN_W-1:0]               len;
	} cfg_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + CASE_OFFSET : c;
	endfunction

	function automatic logic is_boundary(input logic [7:0] c);
		return c == " " || c == 8'h0A || c == 8'h09 || c == "." || c == "," || c == 8'h0D;
	endfunction

endpackage

// ===== rtl/core/name_then_verb_matcher_top.sv =====
// top level of the name-then-verb matcher: handshakes, sticky flag and result register
// Scans a text stream at one byte per clock cycle while not stalled. Each accepted
// byte shifts into a 26-byte window; in the following cycle the whole window is
// compared in parallel against boundary + configured name + each of the nine verb
// patterns, and any hit sets a sticky flag. On the byte marked last, the result
// (reject or pass) reaches the output register when that byte leaves the stage
// register, and the stream state clears so the next stream may start on the very
// next cycle. Input stalls only while a last byte waits behind an untaken result.
// Write the name registers only while no stream is in progress.
module name_then_verb_matcher_top import ntvm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [63:0]          wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           text_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 reject
);

	cfg_t cfg;
	win_t win;
	logic take;
	logic hit;
	logic found;
	logic s1_go;
	logic valid_s1;
	logic last_s1;
	logic match_found_q;
	logic out_valid_q;
	logic reject_q;

	ntvm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	ntvm_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.text_byte (text_byte),
		.last_byte (last_byte),
		.win       (win)
	);

	ntvm_detect u_detect (
		.win (win),
		.cfg (cfg),
		.hit (hit)
	);

	assign s1_go    = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_go;
	assign take     = in_valid && !in_stall;
	assign found    = match_found_q || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			last_s1       <= 1'b0;
			match_found_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
				last_s1  <= last_byte;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				match_found_q <= last_s1 ? 1'b0 : found;
			end
			if (s1_go && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			reject_q <= found;
		end
	end

	assign out_valid = out_valid_q;
	assign reject    = reject_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> out_valid)
		else $error("last item left without a result");

	a_flag_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> !match_found_q)
		else $error("match flag survived end of stream");

	a_zero_len_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cfg.len == '0) |-> !reject)
		else $error("reject with empty name");

endmodule

// ===== rtl/core/ntvm_cfg.sv =====
// name registers and the folded, reversed name used by the compare
module ntvm_cfg import ntvm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [63:0]          wr_data,
	output cfg_t                 cfg
);

	logic [63:0] name_low_q;
	logic [63:0] name_high_q;
	logic [4:0]  name_size_q;
	logic [NAME_REG_BYTES-1:0][7:0] nbytes;
	logic [4:0]  len_clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_low_q  <= '0;
			name_high_q <= '0;
			name_size_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_NAME_LOW:  name_low_q  <= wr_data;
				REG_NAME_HIGH: name_high_q <= wr_data;
				REG_NAME_LEN:  name_size_q <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	assign nbytes      = {name_high_q, name_low_q};
	assign len_clamped = (name_size_q > 5'(NAME_MAX_BYTES)) ? 5'(NAME_MAX_BYTES) : name_size_q;

	// name byte n-1-k lands at position k, next to the pattern
	always_comb begin
		int idx;
		idx = 0;
		cfg.len = LEN_W'(len_clamped);
		for (int k = 0; k < NAME_MAX_BYTES; k++) begin
			idx = int'(len_clamped) - 1 - k;
			if (idx >= 0) begin
				cfg.rname[k] = fold(nbytes[idx[3:0]]);
			end else begin
				cfg.rname[k] = '0;
			end
		end
	end

endmodule

// ===== rtl/core/ntvm_window.sv =====
// window of recent bytes and stream byte count
module ntvm_window import ntvm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] text_byte,
	input  logic       last_byte,
	output win_t       win
);

	win_t win_q;
	logic restart_q;
	logic [WINDOW_BYTES-1:0][7:0] base_bytes;
	logic [SEEN_W-1:0]            base_seen;

	// a new stream starts from an empty window
	assign base_bytes = restart_q ? '0 : win_q.bytes;
	assign base_seen  = restart_q ? '0 : win_q.seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			restart_q <= 1'b0;
		end else if (take) begin
			win_q.bytes <= {base_bytes[WINDOW_BYTES-2:0], text_byte};
			win_q.seen  <= (base_seen == '1) ? base_seen : base_seen + 1'b1;
			restart_q   <= last_byte;
		end
	end

	assign win = win_q;

endmodule

// ===== rtl/core/ntvm_detect.sv =====
// parallel compare of boundary, name and the verb patterns over the window
module ntvm_detect import ntvm_pkg::*; (
	input  win_t win,
	input  cfg_t cfg,
	output logic hit
);

	logic [WINDOW_BYTES-1:0][7:0] fwin;
	logic [WINDOW_BYTES-1:0]      bnd;

	always_comb begin
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			fwin[i] = fold(win.bytes[i]);
			bnd[i]  = is_boundary(win.bytes[i]);
		end
	end

	always_comb begin
		int  plen;
		int  tot;
		int  idx;
		logic pm;
		logic nm;
		logic ok;
		plen = 0;
		tot  = 0;
		idx  = 0;
		pm   = 1'b0;
		nm   = 1'b0;
		ok   = 1'b0;
		hit  = 1'b0;
		for (int p = 0; p < PAT_COUNT; p++) begin
			plen = int'(PAT_LEN[p]);
			tot  = plen + int'(cfg.len);
			pm   = 1'b1;
			for (int j = 0; j < PAT_MAX; j++) begin
				if (j < plen) begin
					idx = plen - 1 - j;
					if (fwin[WIN_IDX_W'(idx)] != PAT_TEXT[p][j]) begin
						pm = 1'b0;
					end
				end
			end
			nm = 1'b1;
			for (int k = 0; k < NAME_MAX_BYTES; k++) begin
				if (k < int'(cfg.len)) begin
					idx = plen + k;
					if (idx < WINDOW_BYTES) begin
						if (fwin[WIN_IDX_W'(idx)] != cfg.rname[k]) begin
							nm = 1'b0;
						end
					end else begin
						nm = 1'b0;
					end
				end
			end
			ok = pm && nm && (tot <= WINDOW_BYTES) && (int'(win.seen) >= tot);
			// boundary byte in front of the name unless the name opens the stream
			if (ok && int'(win.seen) != tot) begin
				if (tot >= WINDOW_BYTES) begin
					ok = 1'b0;
				end else begin
					ok = bnd[WIN_IDX_W'(tot)];
				end
			end
			if (ok && cfg.len != '0) begin
				hit = 1'b1;
			end
		end
	end

endmodule

// ===== bench/name_then_verb_matcher_tb.sv =====
// self-checking testbench for the name-then-verb matcher: byte streams in, predicted verdicts out
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ntvm_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_BYTES = 220;
	localparam int PHASES      = 10;
	localparam int HOLD_CYCLES = 400;
	localparam bit [7:0] SEPS [6] = '{" ", 8'h0A, 8'h09, ".", ",", 8'h0D};

	typedef enum {NAME_RANDOM, NAME_ONES, NAME_ZEROS} name_fill_t;

	class reject_predictor;
		bit [7:0] name_bytes [NAME_MAX_BYTES];
		int unsigned name_size;
		bit [7:0] recent [WINDOW_BYTES];
		int unsigned stream_len;
		bit found;
		bit due [$];
		int unsigned mismatches;
		int unsigned results;
		string verbs [9];

		function new();
			verbs = '{" is ", " was ", " would ", " should ", " thinks ", " feels ",
				" is chill", " is a ", " is the "};
			clear_stream();
		endfunction

		function void clear_stream();
			foreach (recent[i]) recent[i] = 8'h00;
			stream_len = 0;
			found = 1'b0;
		endfunction

		function void write_reg(reg_idx_t idx, bit [63:0] data);
			case (idx)
			REG_NAME_LOW: begin
				for (int i = 0; i < 8; i++) name_bytes[i] = data[8*i +: 8];
			end
			REG_NAME_HIGH: begin
				for (int i = 0; i < 8; i++) name_bytes[8+i] = data[8*i +: 8];
			end
			REG_NAME_LEN: begin
				name_size = (data[4:0] > NAME_MAX_BYTES) ? NAME_MAX_BYTES : data[4:0];
			end
			default: ;
			endcase
		endfunction

		function bit [7:0] lower_ascii(bit [7:0] c);
			return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		endfunction

		function bit lead_sep(bit [7:0] c);
			return c inside {" ", 8'h0A, 8'h09, ".", ",", 8'h0D};
		endfunction

		// window ends with separator (or stream start) + name + verb v
		function bit tail_hit(int unsigned n, int v);
			int unsigned plen;
			int unsigned total;
			bit [7:0] pc;
			plen = verbs[v].len();
			total = n + plen;
			if (total > WINDOW_BYTES || stream_len < total)
				return 1'b0;
			for (int j = 0; j < plen; j++) begin
				pc = verbs[v][j];
				if (lower_ascii(recent[plen-1-j]) != pc)
					return 1'b0;
			end
			for (int j = 0; j < n; j++)
				if (lower_ascii(recent[total-1-j]) != lower_ascii(name_bytes[j]))
					return 1'b0;
			if (stream_len == total)
				return 1'b1;
			if (total >= WINDOW_BYTES)
				return 1'b0;
			return lead_sep(recent[total]);
		endfunction

		function void take_byte(bit [7:0] b, bit last);
			for (int i = WINDOW_BYTES - 1; i > 0; i--) recent[i] = recent[i-1];
			recent[0] = b;
			if (stream_len < 31)
				stream_len++;
			if (name_size != 0)
				foreach (verbs[v])
					if (tail_hit(name_size, v))
						found = 1'b1;
			if (last) begin
				due.push_back(found);
				clear_stream();
			end
		endfunction

		function void note_error(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		function void check_verdict(logic got);
			bit want;
			results++;
			if (due.size() == 0) begin
				note_error($sformatf("result %0d: reject=%b with no verdict due", results, got));
			end else begin
				want = due.pop_front();
				if (got !== want)
					note_error($sformatf("result %0d: reject expected %0b, got %b",
						results, want, got));
			end
		endfunction

		function int unsigned pending();
			return due.size();
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 wr_en     = 1'b0;
	logic [REG_IDX_W-1:0] wr_index  = REG_NAME_LOW;
	logic [63:0]          wr_data   = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [7:0]           text_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 reject;

	reject_predictor rejects;
	bit calm;
	bit hold_req;
	int unsigned bytes_sent;
	int unsigned quiet;
	bit [7:0] cur_name [NAME_MAX_BYTES];
	int unsigned cur_len;
	bit [7:0] txt [$];

	name_then_verb_matcher_top uut (
		.clk, .arst_n, .wr_en, .wr_index, .wr_data,
		.in_valid, .in_stall, .text_byte, .last_byte,
		.out_valid, .out_stall, .reject
	);

	always #2 clk = ~clk;

	function automatic bit [7:0] any_case(bit [7:0] c);
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
			return $urandom_range(1) ? c ^ 8'h20 : c;
		return c;
	endfunction

	function automatic bit [7:0] filler();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 8'($urandom_range("z", "a"));
		if (r < 85)
			return " ";
		return 8'($urandom_range(255));
	endfunction

	task automatic add_plain(string s);
		for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
	endtask

	task automatic add_mixed(string s);
		for (int i = 0; i < s.len(); i++) txt.push_back(any_case(s[i]));
	endtask

	task automatic send_byte(bit [7:0] b, bit last);
		while (!calm && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		rejects.take_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (rejects.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_name();
		bit [63:0] lo;
		bit [63:0] hi;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = cur_name[i];
			hi[8*i +: 8] = cur_name[8+i];
		end
		wr_en    <= 1'b1;
		wr_index <= REG_NAME_LOW;
		wr_data  <= lo;
		@(posedge clk);
		rejects.write_reg(REG_NAME_LOW, lo);
		wr_index <= REG_NAME_HIGH;
		wr_data  <= hi;
		@(posedge clk);
		rejects.write_reg(REG_NAME_HIGH, hi);
		wr_index <= REG_NAME_LEN;
		wr_data  <= 64'(cur_len);
		@(posedge clk);
		rejects.write_reg(REG_NAME_LEN, 64'(cur_len));
		wr_en <= 1'b0;
	endtask

	task automatic pick_name(int unsigned len, name_fill_t fill);
		foreach (cur_name[j]) begin
			case (fill)
			NAME_ONES:  cur_name[j] = 8'hFF;
			NAME_ZEROS: cur_name[j] = 8'h00;
			default: begin
				if (j < len && $urandom_range(99) < 85)
					cur_name[j] = any_case(8'($urandom_range("z", "a")));
				else
					cur_name[j] = 8'($urandom_range(255));
			end
			endcase
		end
		cur_len = len;
		apply_name();
	endtask

	// mostly separator + name + verb sequences, some spoilt, cut short or pure noise
	task automatic compose_stream();
		int unsigned pre;
		int unsigned v;
		bit spoil;
		string verb;
		txt.delete();
		if ($urandom_range(99) >= 80) begin
			repeat ($urandom_range(40, 1)) txt.push_back(8'($urandom_range(255)));
			return;
		end
		repeat ($urandom_range(2, 1)) begin
			pre = ($urandom_range(9) == 0) ? $urandom_range(35, 20) : $urandom_range(6);
			repeat (pre) txt.push_back(any_case(filler()));
			if (txt.size() != 0 || $urandom_range(1)) begin
				if ($urandom_range(99) < 12)
					txt.push_back(any_case(filler()));
				else
					txt.push_back(SEPS[$urandom_range(5)]);
			end
			for (int j = 0; j < cur_len; j++) txt.push_back(any_case(cur_name[j]));
			spoil = $urandom_range(99) < 10;
			if (spoil && cur_len != 0)
				txt[txt.size() - 1 - $urandom_range(cur_len - 1)] = 8'($urandom_range(255));
			v = $urandom_range(8);
			verb = rejects.verbs[v];
			add_mixed(verb);
			if ($urandom_range(99) < 10)
				txt[txt.size() - 1 - $urandom_range(verb.len() - 1)] = any_case(filler());
		end
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(verb.len() - 1, 1)) void'(txt.pop_back());
		else
			repeat ($urandom_range(5)) txt.push_back(any_case(filler()));
	endtask

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				rejects.check_verdict(reject);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !calm && $urandom_range(99) < 25;
		end
	end

	initial begin
		int unsigned start;
		rejects = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero name length passes whatever the text, then name "bob" with a mixed-case hit, a cut-off verb and noise
		txt.delete();
		add_plain("bob is ");
		send_text();
		settle();
		cur_name = '{default: 8'h00};
		cur_name[0] = "b";
		cur_name[1] = "o";
		cur_name[2] = "b";
		cur_len = 3;
		apply_name();
		txt.delete();
		add_plain("Bob is ");
		send_text();
		txt.delete();
		add_plain(".bob wo");
		send_text();
		txt = '{8'h00, 8'hFF};
		send_text();

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
			0: pick_name(NAME_MAX_BYTES, NAME_RANDOM);
			1: pick_name(1, NAME_RANDOM);
			2: pick_name(0, NAME_RANDOM);
			3: pick_name(NAME_MAX_BYTES, NAME_ONES);
			4: pick_name(NAME_MAX_BYTES, NAME_ZEROS);
			default: pick_name($urandom_range(NAME_MAX_BYTES, 1), NAME_RANDOM);
			endcase
			calm = (phase == 5);
			start = bytes_sent;
			if (phase == 1) begin
				// short streams against a held-off output so the input backs up
				hold_req = 1'b1;
				while (bytes_sent - start < 120) begin
					txt.delete();
					repeat ($urandom_range(3, 1)) txt.push_back(8'($urandom_range(255)));
					send_text();
				end
			end
			while (bytes_sent - start < PHASE_BYTES) begin
				compose_stream();
				send_text();
			end
		end
		settle();
		repeat (8) @(posedge clk);
		if (rejects.mismatches == 0 && rejects.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ntvm_pkg.sv
rtl/core/ntvm_cfg.sv
rtl/core/ntvm_window.sv
rtl/core/ntvm_detect.sv
rtl/core/name_then_verb_matcher_top.sv
bench/name_then_verb_matcher_tb.sv
